@@ rtl/mflg_pkg.sv @@
package mflg_pkg;

  localparam int FLOW_W = 28;
  localparam logic [FLOW_W-1:0] FLOW_MAX = {FLOW_W{1'b1}};
  localparam logic [31:0] PUSH_LIMIT = 32'd999999999;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DROPPED = 2'd1,
    ST_SAME    = 2'd2
  } flow_status_t;

  typedef enum logic [5:0] {
    CMD_IDLE, CMD_ADD0, CMD_ADD1, CMD_ADD2, CMD_ADD3, CMD_CLR, CMD_LCLR, CMD_BSEED,
    CMD_BQPOP, CMD_BQV, CMD_BQV2, CMD_BARC, CMD_BARC2, CMD_BARC3, CMD_CHKT, CMD_CHKT2,
    CMD_CUR, CMD_DV, CMD_DV2, CMD_DSCAN, CMD_DS2, CMD_DS3, CMD_DRET, CMD_DRET2,
    CMD_DRET3, CMD_AM, CMD_AM2, CMD_AM3, CMD_AP, CMD_AP2, CMD_AP3, CMD_AP4, CMD_DONE
  } dp_cmd_t;

  typedef struct packed {
    dp_cmd_t cmd;
    logic    take;
  } dp_ctl_t;

  typedef struct packed {
    logic is_solve;
    logic add_ok;
    logic solve_run;
    logic sweep_end;
    logic cur_end;
    logic q_empty;
    logic a_null;
    logic v_is_t;
    logic lvl_zero;
    logic found;
    logic depth_zero;
    logic k_end;
    logic out_full;
  } dp_stat_t;

endpackage

@@ rtl/mflg_ctrl.sv @@
module mflg_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  mflg_pkg::dp_stat_t st,
  output mflg_pkg::dp_ctl_t  ctl
);

  typedef enum logic [5:0] {
    S_IDLE, S_ADD0, S_ADD1, S_ADD2, S_ADD3, S_CLR, S_LCLR, S_BSEED,
    S_BQPOP, S_BQV, S_BQV2, S_BARC, S_BARC2, S_BARC3, S_CHKT, S_CHKT2,
    S_CUR, S_DV, S_DV2, S_DSCAN, S_DS2, S_DS3, S_DRET, S_DRET2,
    S_DRET3, S_AM, S_AM2, S_AM3, S_AP, S_AP2, S_AP3, S_AP4, S_DONE
  } state_t;

  state_t state_r, state_nxt;
  mflg_pkg::dp_cmd_t cmd_r, cmd_nxt;
  logic take;

  assign in_stall = (state_r != S_IDLE) || st.out_full;
  assign take     = in_valid && !in_stall;
  assign ctl.cmd  = cmd_r;
  assign ctl.take = take;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (take) begin
          if (!st.is_solve) state_nxt = st.add_ok ? S_ADD0 : S_IDLE;
          else state_nxt = st.solve_run ? S_LCLR : S_DONE;
        end
      end
      S_ADD0:  state_nxt = S_ADD1;
      S_ADD1:  state_nxt = S_ADD2;
      S_ADD2:  state_nxt = S_ADD3;
      S_ADD3:  state_nxt = S_IDLE;
      S_CLR:   state_nxt = st.sweep_end ? S_IDLE : S_CLR;
      S_LCLR:  state_nxt = st.sweep_end ? S_BSEED : S_LCLR;
      S_BSEED: state_nxt = S_BQPOP;
      S_BQPOP: state_nxt = st.q_empty ? S_CHKT : S_BQV;
      S_BQV:   state_nxt = S_BQV2;
      S_BQV2:  state_nxt = S_BARC;
      S_BARC:  state_nxt = st.a_null ? S_BQPOP : S_BARC2;
      S_BARC2: state_nxt = S_BARC3;
      S_BARC3: state_nxt = S_BARC;
      S_CHKT:  state_nxt = S_CHKT2;
      S_CHKT2: state_nxt = st.lvl_zero ? S_DONE : S_CUR;
      S_CUR:   state_nxt = st.cur_end ? S_DV : S_CUR;
      S_DV:    state_nxt = st.v_is_t ? S_AM : S_DV2;
      S_DV2:   state_nxt = S_DSCAN;
      S_DSCAN: state_nxt = st.a_null ? S_DRET : S_DS2;
      S_DS2:   state_nxt = S_DS3;
      S_DS3:   state_nxt = st.found ? S_DV : S_DSCAN;
      S_DRET:  state_nxt = st.depth_zero ? S_LCLR : S_DRET2;
      S_DRET2: state_nxt = S_DRET3;
      S_DRET3: state_nxt = S_DV;
      S_AM:    state_nxt = st.k_end ? S_AP : S_AM2;
      S_AM2:   state_nxt = S_AM3;
      S_AM3:   state_nxt = S_AM;
      S_AP:    state_nxt = st.k_end ? S_DV : S_AP2;
      S_AP2:   state_nxt = S_AP3;
      S_AP3:   state_nxt = S_AP4;
      S_AP4:   state_nxt = S_AP;
      S_DONE:  state_nxt = S_CLR;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    unique case (state_nxt)
      S_IDLE:  cmd_nxt = mflg_pkg::CMD_IDLE;
      S_ADD0:  cmd_nxt = mflg_pkg::CMD_ADD0;
      S_ADD1:  cmd_nxt = mflg_pkg::CMD_ADD1;
      S_ADD2:  cmd_nxt = mflg_pkg::CMD_ADD2;
      S_ADD3:  cmd_nxt = mflg_pkg::CMD_ADD3;
      S_CLR:   cmd_nxt = mflg_pkg::CMD_CLR;
      S_LCLR:  cmd_nxt = mflg_pkg::CMD_LCLR;
      S_BSEED: cmd_nxt = mflg_pkg::CMD_BSEED;
      S_BQPOP: cmd_nxt = mflg_pkg::CMD_BQPOP;
      S_BQV:   cmd_nxt = mflg_pkg::CMD_BQV;
      S_BQV2:  cmd_nxt = mflg_pkg::CMD_BQV2;
      S_BARC:  cmd_nxt = mflg_pkg::CMD_BARC;
      S_BARC2: cmd_nxt = mflg_pkg::CMD_BARC2;
      S_BARC3: cmd_nxt = mflg_pkg::CMD_BARC3;
      S_CHKT:  cmd_nxt = mflg_pkg::CMD_CHKT;
      S_CHKT2: cmd_nxt = mflg_pkg::CMD_CHKT2;
      S_CUR:   cmd_nxt = mflg_pkg::CMD_CUR;
      S_DV:    cmd_nxt = mflg_pkg::CMD_DV;
      S_DV2:   cmd_nxt = mflg_pkg::CMD_DV2;
      S_DSCAN: cmd_nxt = mflg_pkg::CMD_DSCAN;
      S_DS2:   cmd_nxt = mflg_pkg::CMD_DS2;
      S_DS3:   cmd_nxt = mflg_pkg::CMD_DS3;
      S_DRET:  cmd_nxt = mflg_pkg::CMD_DRET;
      S_DRET2: cmd_nxt = mflg_pkg::CMD_DRET2;
      S_DRET3: cmd_nxt = mflg_pkg::CMD_DRET3;
      S_AM:    cmd_nxt = mflg_pkg::CMD_AM;
      S_AM2:   cmd_nxt = mflg_pkg::CMD_AM2;
      S_AM3:   cmd_nxt = mflg_pkg::CMD_AM3;
      S_AP:    cmd_nxt = mflg_pkg::CMD_AP;
      S_AP2:   cmd_nxt = mflg_pkg::CMD_AP2;
      S_AP3:   cmd_nxt = mflg_pkg::CMD_AP3;
      S_AP4:   cmd_nxt = mflg_pkg::CMD_AP4;
      S_DONE:  cmd_nxt = mflg_pkg::CMD_DONE;
      default: cmd_nxt = mflg_pkg::CMD_IDLE;
    endcase
  end

  // reset starts with a sweep that nulls every adjacency head
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      cmd_r   <= mflg_pkg::CMD_CLR;
    end else begin
      state_r <= state_nxt;
      cmd_r   <= cmd_nxt;
    end
  end

endmodule

@@ rtl/mflg_dp.sv @@
module mflg_dp #(
  parameter int MAX_VERTICES = 512,
  parameter int MAX_ARCS     = 8192,
  parameter int CAP_BITS     = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  mflg_pkg::dp_ctl_t           ctl,
  output mflg_pkg::dp_stat_t          st,
  input  logic                        in_op,
  input  logic [8:0]                  in_from_vertex,
  input  logic [8:0]                  in_to_vertex,
  input  logic [15:0]                 in_capacity,
  input  logic [8:0]                  in_source_vertex,
  input  logic [8:0]                  in_sink_vertex,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [mflg_pkg::FLOW_W-1:0] out_flow_total,
  output logic [1:0]                  out_status
);

  localparam int VW  = $clog2(MAX_VERTICES);
  localparam int LW  = $clog2(MAX_VERTICES + 1);
  localparam int AW  = $clog2(MAX_ARCS);
  localparam int NAW = $clog2(MAX_ARCS + 1);
  localparam int FW  = mflg_pkg::FLOW_W;
  localparam int SW  = ((CAP_BITS > FW) ? CAP_BITS : FW) + 1;
  localparam logic [NAW-1:0] NULL_ARC = NAW'(MAX_ARCS);
  localparam logic [CAP_BITS-1:0] D_INIT =
    (CAP_BITS >= 30) ? CAP_BITS'(mflg_pkg::PUSH_LIMIT) : {CAP_BITS{1'b1}};

  logic [VW-1:0]       head_mem [MAX_ARCS];
  logic [CAP_BITS-1:0] resid_mem [MAX_ARCS];
  logic [NAW-1:0]      next_mem [MAX_ARCS];
  logic [NAW-1:0]      first_mem [MAX_VERTICES];
  logic [LW-1:0]       level_mem [MAX_VERTICES];
  logic [NAW-1:0]      cursor_mem [MAX_VERTICES];
  logic [VW-1:0]       queue_mem [MAX_VERTICES];
  logic [AW-1:0]       stack_mem [MAX_VERTICES];

  logic head_we, resid_we, next_we, first_we, level_we, cursor_we, queue_we, stack_we;
  logic [AW-1:0] head_wa, head_ra, resid_wa, resid_ra, next_wa, next_ra;
  logic [VW-1:0] first_wa, first_ra, level_wa, level_ra, cursor_wa, cursor_ra;
  logic [VW-1:0] queue_wa, queue_ra, stack_wa, stack_ra;
  logic [VW-1:0]       head_wd, head_rd, queue_wd, queue_rd;
  logic [CAP_BITS-1:0] resid_wd, resid_rd;
  logic [NAW-1:0]      next_wd, next_rd, first_wd, first_rd, cursor_wd, cursor_rd;
  logic [LW-1:0]       level_wd, level_rd;
  logic [AW-1:0]       stack_wd, stack_rd;

  logic [VW-1:0]       fr_r, to_r, s_r, t_r, v_r, w_r;
  logic [CAP_BITS-1:0] cap_r, res_r, d_r;
  logic [NAW-1:0]      a_r, nx_r, cnt_r;
  logic [LW-1:0]       lv_r, qhead_r, qtail_r, sw_r, depth_r, k_r;
  logic [FW-1:0]       total_r, out_flow_r;
  logic [1:0]          status_r, out_status_r;
  logic                drop_r, out_valid_r;
  logic [SW-1:0]       sum;
  logic [AW-1:0]       a_idx;

  assign a_idx = a_r[AW-1:0];
  assign sum   = SW'(total_r) + SW'(d_r);

  always_comb begin
    st.is_solve   = in_op;
    st.add_ok     = (32'(in_from_vertex) < MAX_VERTICES) && (32'(in_to_vertex) < MAX_VERTICES)
                    && (32'(cnt_r) <= MAX_ARCS - 2);
    st.solve_run  = (in_source_vertex != in_sink_vertex)
                    && (32'(in_source_vertex) < MAX_VERTICES)
                    && (32'(in_sink_vertex) < MAX_VERTICES);
    st.sweep_end  = (32'(sw_r) == MAX_VERTICES - 1);
    st.cur_end    = (32'(sw_r) == MAX_VERTICES);
    st.q_empty    = (qhead_r == qtail_r);
    st.a_null     = (a_r == NULL_ARC);
    st.v_is_t     = (v_r == t_r);
    st.lvl_zero   = (level_rd == '0);
    st.found      = (res_r != '0) && (level_rd > lv_r);
    st.depth_zero = (depth_r == '0);
    st.k_end      = (k_r == depth_r);
    st.out_full   = out_valid_r;
  end

  // memory port steering
  always_comb begin
    head_we = 1'b0; resid_we = 1'b0; next_we = 1'b0; first_we = 1'b0;
    level_we = 1'b0; cursor_we = 1'b0; queue_we = 1'b0; stack_we = 1'b0;
    head_wa = cnt_r[AW-1:0]; head_wd = to_r; head_ra = a_idx;
    resid_wa = cnt_r[AW-1:0]; resid_wd = cap_r; resid_ra = a_idx;
    next_wa = cnt_r[AW-1:0]; next_wd = first_rd; next_ra = a_idx;
    first_wa = fr_r; first_wd = cnt_r; first_ra = fr_r;
    level_wa = w_r; level_wd = lv_r + 1'b1; level_ra = v_r;
    cursor_wa = v_r; cursor_wd = a_r; cursor_ra = v_r;
    queue_wa = qtail_r[VW-1:0]; queue_wd = w_r; queue_ra = qhead_r[VW-1:0];
    stack_wa = depth_r[VW-1:0]; stack_wd = a_idx; stack_ra = k_r[VW-1:0];
    case (ctl.cmd)
      mflg_pkg::CMD_ADD1: begin
        head_we = 1'b1; resid_we = 1'b1; next_we = 1'b1; first_we = 1'b1;
      end
      mflg_pkg::CMD_ADD2: first_ra = to_r;
      mflg_pkg::CMD_ADD3: begin
        head_we = 1'b1; resid_we = 1'b1; next_we = 1'b1; first_we = 1'b1;
        head_wa = AW'(cnt_r + 1'b1); resid_wa = AW'(cnt_r + 1'b1);
        next_wa = AW'(cnt_r + 1'b1);
        head_wd = fr_r; resid_wd = '0;
        first_wa = to_r; first_wd = cnt_r + 1'b1;
      end
      mflg_pkg::CMD_CLR: begin
        first_we = 1'b1; first_wa = sw_r[VW-1:0]; first_wd = NULL_ARC;
      end
      mflg_pkg::CMD_LCLR: begin
        level_we = 1'b1; level_wa = sw_r[VW-1:0]; level_wd = '0;
      end
      mflg_pkg::CMD_BSEED: begin
        level_we = 1'b1; level_wa = s_r; level_wd = LW'(1);
        queue_we = 1'b1; queue_wa = '0; queue_wd = s_r;
      end
      mflg_pkg::CMD_BQV: begin
        level_ra = queue_rd; first_ra = queue_rd;
      end
      mflg_pkg::CMD_BARC2: level_ra = head_rd;
      mflg_pkg::CMD_BARC3: begin
        if ((res_r != '0) && (level_rd == '0) && (32'(qtail_r) < MAX_VERTICES)) begin
          level_we = 1'b1; queue_we = 1'b1;
        end
      end
      mflg_pkg::CMD_CHKT: level_ra = t_r;
      mflg_pkg::CMD_CUR: begin
        first_ra = sw_r[VW-1:0];
        // cursor copy trails the registered head read by one vertex
        cursor_we = (sw_r != '0); cursor_wa = VW'(sw_r - 1'b1); cursor_wd = first_rd;
      end
      mflg_pkg::CMD_DS2: level_ra = head_rd;
      mflg_pkg::CMD_DS3: begin
        if (st.found) begin
          cursor_we = 1'b1;
          if (32'(depth_r) < MAX_VERTICES) stack_we = 1'b1;
          else cursor_wd = nx_r;
        end
      end
      mflg_pkg::CMD_DRET: begin
        cursor_we = 1'b1; cursor_wd = NULL_ARC; stack_ra = VW'(depth_r - 1'b1);
      end
      mflg_pkg::CMD_DRET2: begin
        head_ra = stack_rd ^ AW'(1); next_ra = stack_rd;
      end
      mflg_pkg::CMD_DRET3: begin
        cursor_we = 1'b1; cursor_wa = head_rd; cursor_wd = next_rd;
      end
      mflg_pkg::CMD_AM2: resid_ra = stack_rd;
      mflg_pkg::CMD_AP2: resid_ra = stack_rd;
      mflg_pkg::CMD_AP3: begin
        resid_we = 1'b1; resid_wa = a_idx; resid_wd = resid_rd - d_r;
        resid_ra = a_idx ^ AW'(1);
      end
      mflg_pkg::CMD_AP4: begin
        resid_we = 1'b1; resid_wa = a_idx ^ AW'(1); resid_wd = resid_rd + d_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    head_rd <= head_mem[head_ra];
  end
  always_ff @(posedge clk) begin
    if (resid_we) resid_mem[resid_wa] <= resid_wd;
    resid_rd <= resid_mem[resid_ra];
  end
  always_ff @(posedge clk) begin
    if (next_we) next_mem[next_wa] <= next_wd;
    next_rd <= next_mem[next_ra];
  end
  always_ff @(posedge clk) begin
    if (first_we) first_mem[first_wa] <= first_wd;
    first_rd <= first_mem[first_ra];
  end
  always_ff @(posedge clk) begin
    if (level_we) level_mem[level_wa] <= level_wd;
    level_rd <= level_mem[level_ra];
  end
  always_ff @(posedge clk) begin
    if (cursor_we) cursor_mem[cursor_wa] <= cursor_wd;
    cursor_rd <= cursor_mem[cursor_ra];
  end
  always_ff @(posedge clk) begin
    if (queue_we) queue_mem[queue_wa] <= queue_wd;
    queue_rd <= queue_mem[queue_ra];
  end
  always_ff @(posedge clk) begin
    if (stack_we) stack_mem[stack_wa] <= stack_wd;
    stack_rd <= stack_mem[stack_ra];
  end

  // payload and walk registers
  always_ff @(posedge clk) begin
    case (ctl.cmd) inside
      mflg_pkg::CMD_IDLE: begin
        if (ctl.take) begin
          fr_r    <= VW'(in_from_vertex);
          to_r    <= VW'(in_to_vertex);
          cap_r   <= CAP_BITS'(in_capacity);
          s_r     <= VW'(in_source_vertex);
          t_r     <= VW'(in_sink_vertex);
          total_r <= '0;
          if (in_source_vertex == in_sink_vertex) status_r <= mflg_pkg::ST_SAME;
          else if (drop_r) status_r <= mflg_pkg::ST_DROPPED;
          else status_r <= mflg_pkg::ST_OK;
        end
      end
      mflg_pkg::CMD_BSEED: begin
        qhead_r <= '0; qtail_r <= LW'(1);
      end
      mflg_pkg::CMD_BQPOP: qhead_r <= qhead_r + 1'b1;
      mflg_pkg::CMD_BQV: v_r <= queue_rd;
      mflg_pkg::CMD_BQV2: begin
        lv_r <= level_rd; a_r <= first_rd;
      end
      mflg_pkg::CMD_BARC2, mflg_pkg::CMD_DS2: begin
        w_r <= head_rd; res_r <= resid_rd; nx_r <= next_rd;
      end
      mflg_pkg::CMD_BARC3: begin
        a_r <= nx_r;
        if ((res_r != '0) && (level_rd == '0) && (32'(qtail_r) < MAX_VERTICES))
          qtail_r <= qtail_r + 1'b1;
      end
      mflg_pkg::CMD_CHKT2: begin
        depth_r <= '0; v_r <= s_r;
      end
      mflg_pkg::CMD_DV: begin
        d_r <= D_INIT; k_r <= '0;
      end
      mflg_pkg::CMD_DV2: begin
        a_r <= cursor_rd; lv_r <= level_rd;
      end
      mflg_pkg::CMD_DS3: begin
        if (!st.found) a_r <= nx_r;
        else if (32'(depth_r) < MAX_VERTICES) begin
          depth_r <= depth_r + 1'b1; v_r <= w_r;
        end
      end
      mflg_pkg::CMD_DRET: if (!st.depth_zero) depth_r <= depth_r - 1'b1;
      mflg_pkg::CMD_DRET2: a_r <= NAW'(stack_rd);
      mflg_pkg::CMD_DRET3: v_r <= head_rd;
      mflg_pkg::CMD_AM: begin
        if (st.k_end) k_r <= '0;
        else k_r <= k_r + 1'b1;
      end
      mflg_pkg::CMD_AM2, mflg_pkg::CMD_AP2: a_r <= NAW'(stack_rd);
      mflg_pkg::CMD_AM3: if (resid_rd < d_r) d_r <= resid_rd;
      mflg_pkg::CMD_AP: begin
        if (st.k_end) begin
          // saturating flow accumulate, then restart from the source
          total_r <= (sum > SW'(mflg_pkg::FLOW_MAX)) ? mflg_pkg::FLOW_MAX : FW'(sum);
          depth_r <= '0;
          v_r     <= s_r;
        end else begin
          k_r <= k_r + 1'b1;
        end
      end
      mflg_pkg::CMD_DONE: begin
        out_flow_r   <= total_r;
        out_status_r <= status_r;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      drop_r      <= 1'b0;
      sw_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      case (ctl.cmd) inside
        mflg_pkg::CMD_IDLE: begin
          if (ctl.take && !in_op && !st.add_ok) drop_r <= 1'b1;
        end
        mflg_pkg::CMD_ADD3: cnt_r <= cnt_r + NAW'(2);
        mflg_pkg::CMD_CLR, mflg_pkg::CMD_LCLR: begin
          if (st.sweep_end) sw_r <= '0;
          else sw_r <= sw_r + 1'b1;
        end
        mflg_pkg::CMD_CHKT2: sw_r <= '0;
        mflg_pkg::CMD_CUR: begin
          if (st.cur_end) sw_r <= '0;
          else sw_r <= sw_r + 1'b1;
        end
        mflg_pkg::CMD_DONE: begin
          out_valid_r <= 1'b1;
          cnt_r       <= '0;
          drop_r      <= 1'b0;
          sw_r        <= '0;
        end
        default: ;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_flow_total = out_flow_r;
  assign out_status     = out_status_r;

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.cmd == mflg_pkg::CMD_DV) |-> (32'(depth_r) <= MAX_VERTICES))
    else $error("path stack beyond its depth");
  a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.cmd == mflg_pkg::CMD_BQPOP) |-> (qhead_r <= qtail_r))
    else $error("bfs queue head passed tail");
  a_arc_pairs: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r[0] == 1'b0) && (32'(cnt_r) <= MAX_ARCS)) else $error("arc count broken");

endmodule

@@ rtl/max_flow_level_graph.sv @@
// add-edge item: when stored, the add states ADD0 to ADD3 write the arc and its reverse
// arc before the next accept; a dropped item returns straight to idle
// solve item: data dependent; each phase runs a level clear over all vertices, a BFS,
// a cursor sweep, and a path search that scans arcs and augments along each path
// found; the result is registered in a closing state, then a head clear over all
// vertices runs. reset (sync, active low) starts that clear
module max_flow_level_graph #(
  parameter int MAX_VERTICES = 512,
  parameter int MAX_ARCS     = 8192,
  parameter int CAP_BITS     = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [8:0]  in_from_vertex,
  input  logic [8:0]  in_to_vertex,
  input  logic [15:0] in_capacity,
  input  logic [8:0]  in_source_vertex,
  input  logic [8:0]  in_sink_vertex,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [27:0] out_flow_total,
  output logic [1:0]  out_status
);

  mflg_pkg::dp_ctl_t  ctl;
  mflg_pkg::dp_stat_t st;

  mflg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .ctl      (ctl)
  );

  mflg_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_ARCS     (MAX_ARCS),
    .CAP_BITS     (CAP_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctl              (ctl),
    .st               (st),
    .in_op            (in_op),
    .in_from_vertex   (in_from_vertex),
    .in_to_vertex     (in_to_vertex),
    .in_capacity      (in_capacity),
    .in_source_vertex (in_source_vertex),
    .in_sink_vertex   (in_sink_vertex),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_flow_total   (out_flow_total),
    .out_status       (out_status)
  );

endmodule
